// ----- rtl/lsbsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsbsc_pkg
// Shared types and constants for the LSB steganography codec: register
// map, field widths and the pipeline stage record.
// ----------------------------------------------------------------------------
package lsbsc_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_DIRECTION      = 2'd0;
   localparam logic [1:0] REG_MESSAGE_LENGTH = 2'd1;
   localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd2;
   localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd3;

   localparam logic DIR_EMBED   = 1'b0;
   localparam logic DIR_EXTRACT = 1'b1;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam int LEN_W   = 7;
   localparam int DIM_W   = 13;
   localparam int POS_W   = 26;
   localparam int AREA_W  = 2 * DIM_W;
   localparam int TOTAL_W = AREA_W + 2;
   localparam int SLEN_W  = 11;
   localparam int DLEN_W  = 32;

   localparam logic [LEN_W-1:0] LENGTH_LIMIT = 7'd100;

   typedef struct packed {
      logic             mode;
      logic [7:0]       sample;
      logic             image_start;
      logic [POS_W-1:0] pos;
   } stage_type;

endpackage

// ----- rtl/lsb_steganography_codec.sv -----
// ----------------------------------------------------------------------------
// lsb_steganography_codec
// Path: input stage with message buffer read, then result register.
// Throughput: one request per cycle; both stages advance together unless the
// result is stalled.
// Synchronous active-high reset clears pipeline valids, bit position, decoded
// length, byte shift, direction and message length, and sets image width and
// height to 1; message buffer is not cleared.
// ----------------------------------------------------------------------------
module lsb_steganography_codec #(
   parameter int MESSAGE_DEPTH = 128,
   parameter int HEADER_BITS   = 32,
   parameter int CHANNELS      = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [6:0]                          req_byte_index,
   input  logic [7:0]                          req_byte_value,
   input  logic [7:0]                          req_sample,
   input  logic                                req_image_start,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_sample_out,
   output logic                                rsp_char_valid,
   output logic [7:0]                          rsp_char_out,
   output logic                                rsp_last,
   output logic                                rsp_too_small,
   // config port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lsbsc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lsbsc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lsbsc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int AW = $clog2(MESSAGE_DEPTH);
   localparam int PW = lsbsc_pkg::POS_W;
   localparam int TW = lsbsc_pkg::TOTAL_W;
   localparam int LW = lsbsc_pkg::SLEN_W;
   localparam int DW = lsbsc_pkg::DLEN_W;

   // config registers
   logic                              direction_ff;
   logic [lsbsc_pkg::LEN_W-1:0]       msg_len_ff;
   logic [lsbsc_pkg::DIM_W-1:0]       width_ff;
   logic [lsbsc_pkg::DIM_W-1:0]       height_ff;
   logic [lsbsc_pkg::AREA_W-1:0]      area_ff;
   logic                              csr_wr;

   // pipeline
   logic                              s1_valid_ff, s1_valid_in;
   lsbsc_pkg::stage_type              s1_ff, s1_in;
   logic [7:0]                        rd_ff;
   logic [7:0]                        mem [MESSAGE_DEPTH];
   logic [PW-1:0]                     pos_ff, pos_in;
   logic [DW-1:0]                     dlen_ff, dlen_in;
   logic [7:0]                        bshift_ff, bshift_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        so_ff, so_in;
   logic                              cv_ff, cv_in;
   logic [7:0]                        co_ff, co_in;
   logic                              ls_ff, ls_in;
   logic                              ts_ff, ts_in;

   logic                              req_acc, adv, s2_go;
   logic [PW-1:0]                     p_eff, k1;
   logic [AW-1:0]                     raddr;

   // stage 2 terms
   logic [TW-1:0]                     total;
   logic [LW-1:0]                     slen;
   logic [TW-1:0]                     p_ext;
   logic [PW-1:0]                     k2;
   logic [PW-4:0]                     idx2;
   logic [4:0]                        hk;
   logic [DW-1:0]                     hdr_vec;
   logic [7:0]                        mbyte;
   logic [2:0]                        bsel;
   logic                              sbit;
   logic                              in_hdr;
   logic [DW-1:0]                     dlen_cur;
   logic [7:0]                        bshift_cur;

   // ---------------- config port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         msg_len_ff   <= '0;
         width_ff     <= lsbsc_pkg::DIM_W'(1);
         height_ff    <= lsbsc_pkg::DIM_W'(1);
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            lsbsc_pkg::REG_DIRECTION:      direction_ff <= csr_pwdata[0];
            lsbsc_pkg::REG_MESSAGE_LENGTH: msg_len_ff <= csr_pwdata[lsbsc_pkg::LEN_W-1:0];
            lsbsc_pkg::REG_IMAGE_WIDTH:    width_ff <= csr_pwdata[lsbsc_pkg::DIM_W-1:0];
            lsbsc_pkg::REG_IMAGE_HEIGHT:   height_ff <= csr_pwdata[lsbsc_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         lsbsc_pkg::REG_DIRECTION:      csr_prdata = 32'(direction_ff);
         lsbsc_pkg::REG_MESSAGE_LENGTH: csr_prdata = 32'(msg_len_ff);
         lsbsc_pkg::REG_IMAGE_WIDTH:    csr_prdata = 32'(width_ff);
         lsbsc_pkg::REG_IMAGE_HEIGHT:   csr_prdata = 32'(height_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   // image area, refreshed every cycle
   always_ff @(posedge clock) begin
      area_ff <= lsbsc_pkg::AREA_W'(width_ff) * lsbsc_pkg::AREA_W'(height_ff);
   end

   // ---------------- handshake ----------------
   assign adv       = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = s1_valid_ff & ~adv;
   assign req_acc   = req_valid & ~req_stall;
   assign s2_go     = s1_valid_ff & adv;

   // ---------------- stage 1: capture, position, buffer read ----------------
   assign p_eff = req_image_start ? '0 : pos_ff;
   assign k1    = p_eff - PW'(HEADER_BITS);
   assign raddr = k1[AW+2:3];

   always_comb begin
      s1_in.mode        = req_mode;
      s1_in.sample      = req_sample;
      s1_in.image_start = req_image_start;
      s1_in.pos         = p_eff;
      s1_valid_in       = req_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
      pos_in            = pos_ff;
      if (req_acc && req_mode == lsbsc_pkg::MODE_SAMPLE) begin
         pos_in = (p_eff != {PW{1'b1}}) ? p_eff + PW'(1) : p_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_mode == lsbsc_pkg::MODE_LOAD &&
          32'(req_byte_index) < MESSAGE_DEPTH) begin
         mem[AW'(req_byte_index)] <= req_byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_ff <= mem[raddr];
      end
   end

   // ---------------- stage 2: embed / extract ----------------
   assign total   = TW'(area_ff) * TW'(CHANNELS);
   assign slen    = LW'(HEADER_BITS) + {msg_len_ff, 3'b000};
   assign p_ext   = TW'(s1_ff.pos);
   assign in_hdr  = s1_ff.pos < PW'(HEADER_BITS);
   assign k2      = s1_ff.pos - PW'(HEADER_BITS);
   assign idx2    = k2[PW-1:3];
   assign hk      = 5'(HEADER_BITS - 1) - s1_ff.pos[4:0];
   assign hdr_vec = DW'(msg_len_ff);
   assign mbyte   = (32'(idx2) < MESSAGE_DEPTH) ? rd_ff : 8'd0;
   assign bsel    = 3'd7 - k2[2:0];
   assign sbit    = in_hdr ? hdr_vec[hk] : mbyte[bsel];

   assign dlen_cur   = s1_ff.image_start ? '0 : dlen_ff;
   assign bshift_cur = s1_ff.image_start ? '0 : bshift_ff;

   always_comb begin
      so_in        = 8'd0;
      cv_in        = 1'b0;
      co_in        = 8'd0;
      ls_in        = 1'b0;
      ts_in        = 1'b0;
      dlen_in      = dlen_ff;
      bshift_in    = bshift_ff;
      rsp_valid_in = s2_go ? 1'b1 : (adv ? 1'b0 : rsp_valid_ff);
      if (s2_go && s1_ff.mode == lsbsc_pkg::MODE_SAMPLE) begin
         so_in     = s1_ff.sample;
         dlen_in   = dlen_cur;
         bshift_in = bshift_cur;
         if (direction_ff == lsbsc_pkg::DIR_EMBED) begin
            if (msg_len_ff >= lsbsc_pkg::LENGTH_LIMIT || TW'(slen) > total) begin
               ts_in = 1'b1;
            end else if (p_ext < TW'(slen)) begin
               so_in = {s1_ff.sample[7:1], sbit};
               ls_in = (p_ext == TW'(slen - LW'(1)));
            end
         end else if (p_ext < total) begin
            if (in_hdr) begin
               dlen_in = {dlen_cur[DW-2:0], s1_ff.sample[0]};
            end else if (!dlen_cur[DW-1]) begin
               if (DW'(idx2) < dlen_cur) begin
                  bshift_in = {bshift_cur[6:0], s1_ff.sample[0]};
                  if (k2[2:0] == 3'd7) begin
                     cv_in = 1'b1;
                     co_in = {bshift_cur[6:0], s1_ff.sample[0]};
                     ls_in = (DW'(idx2) == dlen_cur - DW'(1));
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         dlen_ff      <= '0;
         bshift_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         dlen_ff      <= dlen_in;
         bshift_ff    <= bshift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         so_ff <= so_in;
         cv_ff <= cv_in;
         co_ff <= co_in;
         ls_ff <= ls_in;
         ts_ff <= ts_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = so_ff;
   assign rsp_char_valid = cv_ff;
   assign rsp_char_out   = co_ff;
   assign rsp_last       = ls_ff;
   assign rsp_too_small  = ts_ff;

endmodule

// ----- test/tb_lsb_steganography_codec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsb_steganography_codec
// Self-checking bench for the LSB steganography codec. Requests come from a
// queue and go through a valid/stall driver. Each accepted request also goes
// through a local codec predictor, which keeps its own message store,
// bit position, decoded header and character shift. Every result is
// compared field by field with the oldest prediction. Several register
// settings are covered: embed and extract, the longest message, a length
// that is out of range, images that are too small, and image sides of 4096
// pixels.
// ----------------------------------------------------------------------------
module tb_lsb_steganography_codec;

   localparam int HEADER_BITS    = 32;
   localparam int CHANNELS       = 3;
   localparam int STORE_DEPTH    = 128;
   localparam int TOTAL_REQUESTS = 1050;
   localparam logic [lsbsc_pkg::POS_W-1:0] POS_LIMIT = '1;

   typedef struct packed {
      logic       mode;
      logic [6:0] byte_index;
      logic [7:0] byte_value;
      logic [7:0] sample;
      logic       image_start;
   } codec_request_type;

   typedef struct packed {
      logic [7:0] sample_out;
      logic       char_valid;
      logic [7:0] char_out;
      logic       last;
      logic       too_small;
   } codec_result_type;

   localparam int REQ_W = $bits(codec_request_type);

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_mode = lsbsc_pkg::MODE_LOAD;
   logic [6:0]                       req_byte_index = '0;
   logic [7:0]                       req_byte_value = '0;
   logic [7:0]                       req_sample = '0;
   logic                             req_image_start = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [7:0]                       rsp_sample_out;
   logic                             rsp_char_valid;
   logic [7:0]                       rsp_char_out;
   logic                             rsp_last;
   logic                             rsp_too_small;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [lsbsc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [lsbsc_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [lsbsc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   lsb_steganography_codec i_dut (.*);

   codec_request_type request_q[$];
   codec_result_type  expected_q[$];
   logic              req_taken = 1'b0;
   int                error_count = 0;
   int                sent_count = 0;
   int                rsp_count = 0;
   int                queued_count = 0;
   bit                loaded [STORE_DEPTH];

   // predictor state
   logic                              cfg_dir = lsbsc_pkg::DIR_EMBED;
   logic [lsbsc_pkg::LEN_W-1:0]       cfg_len = '0;
   logic [lsbsc_pkg::DIM_W-1:0]       cfg_width = 13'd1;
   logic [lsbsc_pkg::DIM_W-1:0]       cfg_height = 13'd1;
   logic [7:0]                        msg_store [STORE_DEPTH];
   logic [lsbsc_pkg::POS_W-1:0]       bit_pos = '0;
   logic [lsbsc_pkg::DLEN_W-1:0]      dec_len = '0;
   logic [7:0]                        char_shift = '0;

   initial forever #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic codec_result_type predict_lsb_output(input codec_request_type r);
      codec_result_type             res;
      logic [63:0]                  area;
      logic [63:0]                  span;
      logic [lsbsc_pkg::POS_W-1:0]  p;
      logic [lsbsc_pkg::POS_W-1:0]  k;
      logic [31:0]                  hdr;
      res = '0;
      if (r.mode == lsbsc_pkg::MODE_LOAD) begin
         msg_store[r.byte_index] = r.byte_value;
         return res;
      end
      if (r.image_start) begin
         bit_pos = '0;
         dec_len = '0;
         char_shift = '0;
      end
      area = 64'(CHANNELS) * cfg_width * cfg_height;
      span = 64'(HEADER_BITS) + 64'(cfg_len) * 8;
      p = bit_pos;
      k = p - lsbsc_pkg::POS_W'(HEADER_BITS);
      res.sample_out = r.sample;
      if (cfg_dir == lsbsc_pkg::DIR_EMBED) begin
         if (cfg_len >= lsbsc_pkg::LENGTH_LIMIT || span > area) begin
            res.too_small = 1'b1;
         end else if (p < span) begin
            hdr = 32'(cfg_len);
            res.sample_out[0] = (p < HEADER_BITS) ? hdr[31 - p[4:0]]
                                                  : msg_store[k[9:3]][3'd7 - k[2:0]];
            res.last = (p == span - 1);
         end
      end else if (p < area) begin
         if (p < HEADER_BITS) begin
            dec_len = {dec_len[30:0], r.sample[0]};
         end else if (!dec_len[31] && 32'(k >> 3) < dec_len) begin
            char_shift = {char_shift[6:0], r.sample[0]};
            if (k[2:0] == 3'd7) begin
               res.char_valid = 1'b1;
               res.char_out = char_shift;
               res.last = (32'(k >> 3) == dec_len - 1);
            end
         end
      end
      if (bit_pos != POS_LIMIT) bit_pos++;
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH response %0d: %s", rsp_count, what);
      error_count++;
   endtask

   function automatic bit gap_now(input int n);
      return (n < 300 || n >= 600) && $urandom_range(0, 99) < 12;
   endfunction

   // request driver
   always @(negedge clock) begin
      codec_request_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         if (request_q.size() != 0 && !gap_now(sent_count)) begin
            nxt = request_q.pop_front();
            req_mode        <= nxt.mode;
            req_byte_index  <= nxt.byte_index;
            req_byte_value  <= nxt.byte_value;
            req_sample      <= nxt.sample;
            req_image_start <= nxt.image_start;
            req_valid       <= 1'b1;
            sent_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= gap_now(rsp_count);
   end

   // monitor and checker
   always @(posedge clock) begin
      codec_result_type got;
      codec_result_type want;
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_q.insert(expected_q.size(), predict_lsb_output({req_mode,
               req_byte_index, req_byte_value, req_sample, req_image_start}));
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_sample_out, rsp_char_valid, rsp_char_out, rsp_last, rsp_too_small};
            if (expected_q.size() == 0) begin
               flag_mismatch("response with no request pending");
            end else begin
               want = expected_q.pop_front();
               if (got.sample_out !== want.sample_out)
                  flag_mismatch($sformatf("sample_out %02h, want %02h",
                     got.sample_out, want.sample_out));
               if (got.char_valid !== want.char_valid)
                  flag_mismatch($sformatf("char_valid %b, want %b",
                     got.char_valid, want.char_valid));
               if (got.char_out !== want.char_out)
                  flag_mismatch($sformatf("char_out %02h, want %02h",
                     got.char_out, want.char_out));
               if (got.last !== want.last)
                  flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
               if (got.too_small !== want.too_small)
                  flag_mismatch($sformatf("too_small %b, want %b",
                     got.too_small, want.too_small));
            end
            rsp_count++;
         end
      end
   end

   task automatic csr_write(input logic [1:0] reg_idx,
                            input logic [lsbsc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (reg_idx)
         lsbsc_pkg::REG_DIRECTION:      cfg_dir = value[0];
         lsbsc_pkg::REG_MESSAGE_LENGTH: cfg_len = value[lsbsc_pkg::LEN_W-1:0];
         lsbsc_pkg::REG_IMAGE_WIDTH:    cfg_width = value[lsbsc_pkg::DIM_W-1:0];
         lsbsc_pkg::REG_IMAGE_HEIGHT:   cfg_height = value[lsbsc_pkg::DIM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (request_q.size() != 0 || req_valid || expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic queue_load(input logic [6:0] idx, input logic [7:0] val);
      codec_request_type r;
      r = REQ_W'($urandom);
      r.mode = lsbsc_pkg::MODE_LOAD;
      r.byte_index = idx;
      r.byte_value = val;
      request_q.insert(request_q.size(), r);
      loaded[idx] = 1'b1;
      queued_count++;
   endtask

   task automatic queue_sample(input logic [7:0] smp, input logic start);
      codec_request_type r;
      r = REQ_W'($urandom);
      r.mode = lsbsc_pkg::MODE_SAMPLE;
      r.sample = smp;
      r.image_start = start;
      request_q.insert(request_q.size(), r);
      queued_count++;
   endtask

   task automatic set_config(input logic dir, input logic [lsbsc_pkg::LEN_W-1:0] len,
                             input logic [lsbsc_pkg::DIM_W-1:0] w,
                             input logic [lsbsc_pkg::DIM_W-1:0] h);
      wait_drained();
      csr_write(lsbsc_pkg::REG_DIRECTION, 32'(dir));
      csr_write(lsbsc_pkg::REG_MESSAGE_LENGTH, 32'(len));
      csr_write(lsbsc_pkg::REG_IMAGE_WIDTH, 32'(w));
      csr_write(lsbsc_pkg::REG_IMAGE_HEIGHT, 32'(h));
      // every byte the embedder may read must be loaded first
      if (dir == lsbsc_pkg::DIR_EMBED && len < lsbsc_pkg::LENGTH_LIMIT) begin
         for (int i = 0; i < len; i++) begin
            if (!loaded[i]) queue_load(7'(i), 8'($urandom));
         end
      end
   endtask

   task automatic embed_run(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 4) queue_load(7'($urandom), 8'($urandom));
         queue_sample(8'($urandom), i == 0);
      end
   endtask

   task automatic embed_frame();
      int          span;
      longint      area;
      span = HEADER_BITS + 8 * cfg_len;
      area = longint'(CHANNELS) * cfg_width * cfg_height;
      if (cfg_len >= lsbsc_pkg::LENGTH_LIMIT || span > area) begin
         embed_run($urandom_range(2, 8));
      end else if ($urandom_range(0, 7) == 0) begin
         embed_run($urandom_range(1, span));
      end else begin
         embed_run(span + $urandom_range(0, 4));
      end
   endtask

   task automatic extract_frame();
      logic [31:0] hdr;
      int          body;
      int          kind;
      kind = $urandom_range(0, 9);
      hdr = $urandom_range(0, 8);
      if (kind == 0) begin
         hdr = 32'h8000_0000 | $urandom;
      end else if (kind == 1) begin
         hdr = $urandom & 32'h7FFF_FFFF;
      end
      body = (kind <= 1) ? $urandom_range(0, 40) : 8 * hdr + $urandom_range(0, 5);
      for (int i = 0; i < HEADER_BITS; i++) queue_sample({7'($urandom), hdr[31 - i]}, i == 0);
      for (int i = 0; i < body; i++) queue_sample(8'($urandom), 1'b0);
   endtask

   task automatic gen_traffic(input int n);
      int stop;
      int pick;
      stop = queued_count + n;
      while (queued_count < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            queue_load(7'($urandom), 8'($urandom));
         end else if (pick < 12) begin
            queue_sample(8'($urandom), $urandom_range(0, 19) == 0);
         end else if (cfg_dir == lsbsc_pkg::DIR_EMBED) begin
            embed_frame();
         end else begin
            extract_frame();
         end
      end
   endtask

   function automatic logic [lsbsc_pkg::DIM_W-1:0] pick_dim();
      int r;
      r = $urandom_range(0, 11);
      if (r == 0) return 13'd4096;
      if (r == 1) return 13'd1;
      return 13'($urandom_range(1, 6));
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset settings: a one-pixel image cannot hold the header
      queue_load(7'd0, 8'hFF);
      queue_load(7'd127, 8'h00);
      queue_sample(8'hFF, 1'b1);
      queue_sample(8'h00, 1'b0);
      // length out of range
      set_config(lsbsc_pkg::DIR_EMBED, 7'd127, 13'd4096, 13'd4096);
      queue_sample(8'hFF, 1'b1);
      queue_sample(8'h00, 1'b0);
      queue_sample(8'h01, 1'b0);
      // longest message, 4096 by 4096 image: header and first characters
      set_config(lsbsc_pkg::DIR_EMBED, 7'd99, 13'd4096, 13'd4096);
      embed_run(HEADER_BITS + 8 * 8 + 2);
      // header only, image just large enough, then samples past the image
      set_config(lsbsc_pkg::DIR_EMBED, 7'd0, 13'd1, 13'd11);
      embed_run(36);
      set_config(lsbsc_pkg::DIR_EMBED, 7'd5, 13'd3, 13'd4);
      gen_traffic(30);
      set_config(lsbsc_pkg::DIR_EXTRACT, 7'd0, 13'd4096, 13'd1);
      gen_traffic(80);
      set_config(lsbsc_pkg::DIR_EXTRACT, 7'd3, 13'd1, 13'd4096);
      gen_traffic(80);
      // image shorter than the header
      set_config(lsbsc_pkg::DIR_EXTRACT, 7'd0, 13'd2, 13'd5);
      gen_traffic(60);

      while (queued_count < TOTAL_REQUESTS) begin
         set_config(1'($urandom),
                    ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                                 : 7'($urandom_range(0, 12)),
                    pick_dim(), pick_dim());
         gen_traffic($urandom_range(40, 100));
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
